// File: rtl/core/gasa_pkg.sv
// Shared constants and types for the glyph atlas shelf allocator.
package gasa_pkg;

   localparam int unsigned PAGE_SIZE = 256;
   localparam int unsigned NUM_PAGES = 8;
   localparam int unsigned PAGE_W = $clog2(NUM_PAGES);
   localparam int unsigned PCNT_W = $clog2(NUM_PAGES + 1);
   localparam int unsigned CODE_W = 21;
   localparam int unsigned DIM_W = 9;
   localparam int unsigned STAT_W = 2;

   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_PAGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;

   // Stored placement of one glyph.
   typedef struct packed {
      logic [2:0]       page;
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } loc_type;

   // One result beat held before it goes out.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              hit;
      loc_type           loc;
   } result_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic take_hit;
      logic fail_full;
      logic page_try;
      logic fail_page;
      logic out_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hit;
      logic scan_done;
      logic table_full;
      logic fit;
      logic last_page;
   } stat_type;

endpackage

// File: rtl/core/gasa_if.sv
// Valid/ready channel interfaces for requests and results.
interface gasa_req_if;
   logic                            valid;
   logic                            ready;
   logic [gasa_pkg::CODE_W-1:0]     char_code;
   logic [gasa_pkg::DIM_W-1:0]      glyph_width;
   logic [gasa_pkg::DIM_W-1:0]      glyph_height;

   modport source (output valid, char_code, glyph_width, glyph_height, input ready);
   modport sink (input valid, char_code, glyph_width, glyph_height, output ready);
endinterface

interface gasa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gasa_pkg::STAT_W-1:0]     status;
   logic                            cache_hit;
   logic [2:0]                      page_number;
   logic [gasa_pkg::DIM_W-1:0]      left_edge;
   logic [gasa_pkg::DIM_W-1:0]      top_edge;
   logic [gasa_pkg::DIM_W-1:0]      right_edge;
   logic [gasa_pkg::DIM_W-1:0]      bottom_edge;
   logic [gasa_pkg::DIM_W-1:0]      placed_width;
   logic [gasa_pkg::DIM_W-1:0]      placed_height;

   modport source (output valid, status, cache_hit, page_number, left_edge, top_edge,
                   right_edge, bottom_edge, placed_width, placed_height, input ready);
   modport sink (input valid, status, cache_hit, page_number, left_edge, top_edge,
                 right_edge, bottom_edge, placed_width, placed_height, output ready);
endinterface

// File: rtl/core/glyph_atlas_shelf_allocator.sv
// A request is captured, then the table is scanned with one registered cache read per stored
// entry; on a miss with room left in the table the pages are tried one at a time, and at the
// end the result register is loaded.
// One request is in work at a time; a finished beat may wait while the next is taken.
// Synchronous active-high reset empties the table and all pages; the memory is not cleared.
module glyph_atlas_shelf_allocator #(
   parameter int unsigned CACHE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   gasa_req_if.sink     req_chan,
   gasa_rsp_if.source   rsp_chan
);

   gasa_pkg::cmd_type    cmd;
   gasa_pkg::stat_type   stat;
   gasa_pkg::result_type out_res;

   gasa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gasa_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .in_code (req_chan.char_code),
      .in_w    (req_chan.glyph_width),
      .in_h    (req_chan.glyph_height),
      .cmd     (cmd),
      .stat    (stat),
      .out_res (out_res)
   );

   // Drive the result beat
   assign rsp_chan.status        = out_res.status;
   assign rsp_chan.cache_hit     = out_res.hit;
   assign rsp_chan.page_number   = out_res.loc.page;
   assign rsp_chan.left_edge     = out_res.loc.x;
   assign rsp_chan.top_edge      = out_res.loc.y;
   assign rsp_chan.right_edge    = out_res.loc.x + out_res.loc.w;
   assign rsp_chan.bottom_edge   = out_res.loc.y + out_res.loc.h;
   assign rsp_chan.placed_width  = out_res.loc.w;
   assign rsp_chan.placed_height = out_res.loc.h;

`ifndef SYNTHESIS
   a_fail_clears_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (out_res.status != gasa_pkg::STAT_OK))
         |-> (!out_res.hit && (out_res.loc == '0)))
      else $error("failure beat carries placement data");

   a_hit_is_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && out_res.hit) |-> (out_res.status == gasa_pkg::STAT_OK))
      else $error("cache hit with failure status");

   a_one_command : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.scan_step, cmd.take_hit, cmd.fail_full, cmd.out_load}))
      else $error("conflicting controller commands");
`endif

endmodule

// File: rtl/core/gasa_ctrl.sv
// Sequencer for lookup, page walk and result delivery.
module gasa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  gasa_pkg::stat_type  stat,
   output gasa_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      PAGE,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = SCAN;
            end
         end
         SCAN: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = DONE;
            end else if (stat.scan_done) begin
               if (stat.table_full) begin
                  cmd.fail_full = 1'b1;
                  state_in      = DONE;
               end else begin
                  state_in = PAGE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         PAGE: begin
            cmd.page_try = 1'b1;
            if (stat.fit) begin
               state_in = DONE;
            end else if (stat.last_page) begin
               cmd.fail_page = 1'b1;
               state_in      = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // Hold the result valid until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/gasa_dp.sv
// Cache table, per-page shelf state, packing arithmetic and result registers.
module gasa_dp #(
   parameter int unsigned CACHE_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gasa_pkg::CODE_W-1:0]   in_code,
   input  logic [gasa_pkg::DIM_W-1:0]    in_w,
   input  logic [gasa_pkg::DIM_W-1:0]    in_h,
   input  gasa_pkg::cmd_type             cmd,
   output gasa_pkg::stat_type            stat,
   output gasa_pkg::result_type          out_res
);

   localparam int unsigned AW = $clog2(CACHE_ENTRIES);
   localparam int unsigned FW = $clog2(CACHE_ENTRIES + 1);
   localparam int unsigned DW = gasa_pkg::DIM_W;
   localparam int unsigned PW = gasa_pkg::PAGE_W;
   localparam int unsigned NP = gasa_pkg::NUM_PAGES;
   localparam logic [DW+1:0] PSIZE = (DW + 2)'(gasa_pkg::PAGE_SIZE);

   // Cache memory
   logic [gasa_pkg::CODE_W-1:0] key_mem [CACHE_ENTRIES];
   gasa_pkg::loc_type           loc_mem [CACHE_ENTRIES];
   logic [gasa_pkg::CODE_W-1:0] key_rd_ff;
   gasa_pkg::loc_type           loc_rd_ff;

   // Request and scan registers
   logic [gasa_pkg::CODE_W-1:0] code_ff;
   logic [DW-1:0]               w_ff, h_ff;
   logic [FW-1:0]               idx_ff, idx_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [PW-1:0]               pg_ff, pg_in;
   logic [gasa_pkg::PCNT_W-1:0] pages_ff, pages_in;

   // Shelf state per page
   logic [DW-1:0] cur_x_ff [NP];
   logic [DW-1:0] top_y_ff [NP];
   logic [DW-1:0] max_h_ff [NP];

   gasa_pkg::result_type res_ff, res_in;
   gasa_pkg::result_type out_ff;

   // Packing arithmetic for the page under test
   logic [DW-1:0]   x, y, mh, px, py, nmh;
   logic [DW+1:0]   ew, eh, xw, yh, ny, nyh;
   logic            oversize, row_full, fit, place;
   gasa_pkg::loc_type new_loc;

   always_comb begin
      x        = cur_x_ff[pg_ff];
      y        = top_y_ff[pg_ff];
      mh       = max_h_ff[pg_ff];
      ew       = (DW + 2)'(w_ff);
      eh       = (DW + 2)'(h_ff);
      xw       = (DW + 2)'(x) + ew;
      yh       = (DW + 2)'(y) + eh;
      ny       = (DW + 2)'(y) + (DW + 2)'(mh);
      nyh      = ny + eh;
      oversize = (ew > PSIZE) || (eh > PSIZE);
      row_full = (xw > PSIZE);
      fit      = !oversize && !(yh > PSIZE) && !(row_full && (nyh > PSIZE));
      px       = row_full ? '0 : x;
      py       = row_full ? ny[DW-1:0] : y;
      if (row_full) begin
         nmh = h_ff;
      end else begin
         nmh = (h_ff > mh) ? h_ff : mh;
      end
      new_loc.page = 3'(pg_ff);
      new_loc.x    = px;
      new_loc.y    = py;
      new_loc.w    = w_ff;
      new_loc.h    = h_ff;
   end

   assign place = cmd.page_try && fit;

   assign stat.hit        = rd_vld_ff && (key_rd_ff == code_ff);
   assign stat.scan_done  = !rd_vld_ff && (idx_ff == fill_ff);
   assign stat.table_full = (fill_ff == FW'(CACHE_ENTRIES));
   assign stat.fit        = fit;
   assign stat.last_page  = ((gasa_pkg::PCNT_W)'(pg_ff) == pages_ff)
                            || (pg_ff == PW'(NP - 1));

   // Next values for scan, page walk and result
   always_comb begin
      idx_in    = idx_ff;
      rd_vld_in = 1'b0;
      pg_in     = pg_ff;
      fill_in   = fill_ff;
      pages_in  = pages_ff;
      res_in    = res_ff;
      if (cmd.capture) begin
         idx_in = '0;
         pg_in  = '0;
      end
      if (cmd.scan_step && (idx_ff != fill_ff)) begin
         rd_vld_in = 1'b1;
         idx_in    = idx_ff + 1'b1;
      end
      if (cmd.take_hit) begin
         res_in.status = gasa_pkg::STAT_OK;
         res_in.hit    = 1'b1;
         res_in.loc    = loc_rd_ff;
      end
      if (cmd.fail_full) begin
         res_in        = '0;
         res_in.status = gasa_pkg::STAT_TABLE_FULL;
      end
      if (cmd.fail_page) begin
         res_in        = '0;
         res_in.status = gasa_pkg::STAT_NO_PAGE;
      end
      if (cmd.page_try && !fit) begin
         pg_in = pg_ff + 1'b1;
      end
      if (place) begin
         res_in.status = gasa_pkg::STAT_OK;
         res_in.hit    = 1'b0;
         res_in.loc    = new_loc;
         fill_in       = fill_ff + 1'b1;
         if ((gasa_pkg::PCNT_W)'(pg_ff) == pages_ff) begin
            pages_in = pages_ff + 1'b1;
         end
      end
   end

   // Control and shelf state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         fill_ff   <= '0;
         pages_ff  <= '0;
         for (int i = 0; i < NP; i++) begin
            cur_x_ff[i] <= '0;
            top_y_ff[i] <= '0;
            max_h_ff[i] <= '0;
         end
      end else begin
         rd_vld_ff <= rd_vld_in;
         fill_ff   <= fill_in;
         pages_ff  <= pages_in;
         if (place) begin
            cur_x_ff[pg_ff] <= px + w_ff;
            top_y_ff[pg_ff] <= py;
            max_h_ff[pg_ff] <= nmh;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= in_code;
         w_ff    <= in_w;
         h_ff    <= in_h;
      end
      idx_ff <= idx_in;
      pg_ff  <= pg_in;
      res_ff <= res_in;
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   // Cache write at the fill point, registered read at the scan index
   always_ff @(posedge clock) begin
      if (place) begin
         key_mem[fill_ff[AW-1:0]] <= code_ff;
         loc_mem[fill_ff[AW-1:0]] <= new_loc;
      end
      key_rd_ff <= key_mem[idx_ff[AW-1:0]];
      loc_rd_ff <= loc_mem[idx_ff[AW-1:0]];
   end

   assign out_res = out_ff;

endmodule
